// ===== hw/rtl/phls_pkg.sv =====
// ----------------------------------------------------------------------------
// phls_pkg
// Shared types, codes and character helpers for the password hash line
// scanner: line phases, crypt prefix matcher states and algorithm codes.
// ----------------------------------------------------------------------------
`default_nettype none

package phls_pkg;

  // Default width of the byte position counters
  localparam int unsigned OFFSET_BITS_DEF = 32;

  // Width of the reported byte offset field
  localparam int unsigned OUT_OFFSET_BITS = 32;

  // File layout codes held in the configuration register
  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_SHADOW   = 2'd1;
  localparam logic [1:0] KIND_HTPASSWD = 2'd2;

  // Finding kinds
  localparam logic FIND_EMPTY_PW = 1'b0;
  localparam logic FIND_HASH     = 1'b1;

  // Algorithm codes
  localparam logic [3:0] ALG_MD5CRYPT = 4'd0;
  localparam logic [3:0] ALG_APR1     = 4'd1;
  localparam logic [3:0] ALG_BCRYPT   = 4'd2;
  localparam logic [3:0] ALG_SHA256   = 4'd3;
  localparam logic [3:0] ALG_SHA512   = 4'd4;
  localparam logic [3:0] ALG_SCRYPT   = 4'd5;
  localparam logic [3:0] ALG_YESCRYPT = 4'd6;
  localparam logic [3:0] ALG_GOSTYES  = 4'd7;
  localparam logic [3:0] ALG_SHA1B64  = 4'd8;
  localparam logic [3:0] ALG_DESCRYPT = 4'd9;

  // Length of a traditional DES crypt string
  localparam logic [3:0] DES_LEN  = 4'd13;
  localparam logic [3:0] HLEN_MAX = 4'd15;

  // Classes of the first hash character
  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_LOCK  = 2'd1;
  localparam logic [1:0] CLS_OTHER = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23; // '#'
  localparam logic [7:0] CH_COLON  = 8'h3A; // ':'
  localparam logic [7:0] CH_STAR   = 8'h2A; // '*'
  localparam logic [7:0] CH_BANG   = 8'h21; // '!'
  localparam logic [7:0] CH_DOLLAR = 8'h24; // '$'
  localparam logic [7:0] CH_LBRACE = 8'h7B; // '{'
  localparam logic [7:0] CH_RBRACE = 8'h7D; // '}'

  // Line phases
  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_USER  = 3'd1,
    PH_HASH  = 3'd2,
    PH_AFTER = 3'd3,
    PH_SKIP  = 3'd4
  } phase_t;

  // Prefix matcher states
  typedef logic [4:0] pm_t;
  localparam pm_t PM_START  = 5'd0;
  localparam pm_t PM_DOL    = 5'd1;
  localparam pm_t PM_BRACE  = 5'd2;
  localparam pm_t PM_D1     = 5'd3;
  localparam pm_t PM_DA     = 5'd4;
  localparam pm_t PM_D2     = 5'd5;
  localparam pm_t PM_D5     = 5'd6;
  localparam pm_t PM_D6     = 5'd7;
  localparam pm_t PM_D7     = 5'd8;
  localparam pm_t PM_DY     = 5'd9;
  localparam pm_t PM_DG     = 5'd10;
  localparam pm_t PM_DAP    = 5'd11;
  localparam pm_t PM_DAPR   = 5'd12;
  localparam pm_t PM_DAPR1  = 5'd13;
  localparam pm_t PM_D2X    = 5'd14;
  localparam pm_t PM_DGY    = 5'd15;
  localparam pm_t PM_BS     = 5'd16;
  localparam pm_t PM_BSH    = 5'd17;
  localparam pm_t PM_BSHA   = 5'd18;
  localparam pm_t PM_HIT    = 5'd20;
  localparam pm_t PM_HIT_HI = 5'd28;
  localparam pm_t PM_DEAD   = 5'd31;

  // Hit state for a given algorithm code
  function automatic pm_t pm_hit(input logic [3:0] alg);
    pm_hit = PM_HIT + {1'b0, alg};
  endfunction

  // Advance the crypt prefix matcher by one hash character
  function automatic pm_t prefix_next(input pm_t s, input logic [7:0] c);
    pm_t n;
    n = PM_DEAD;
    case (s)
      PM_START: begin
        if (c == CH_DOLLAR) n = PM_DOL;
        else if (c == CH_LBRACE) n = PM_BRACE;
      end
      PM_DOL: begin
        case (c)
          "1":     n = PM_D1;
          "a":     n = PM_DA;
          "2":     n = PM_D2;
          "5":     n = PM_D5;
          "6":     n = PM_D6;
          "7":     n = PM_D7;
          "y":     n = PM_DY;
          "g":     n = PM_DG;
          default: n = PM_DEAD;
        endcase
      end
      PM_D1:    if (c == CH_DOLLAR) n = pm_hit(ALG_MD5CRYPT);
      PM_DA:    if (c == "p") n = PM_DAP;
      PM_DAP:   if (c == "r") n = PM_DAPR;
      PM_DAPR:  if (c == "1") n = PM_DAPR1;
      PM_DAPR1: if (c == CH_DOLLAR) n = pm_hit(ALG_APR1);
      PM_D2:    if (c == "a" || c == "b" || c == "y") n = PM_D2X;
      PM_D2X:   if (c == CH_DOLLAR) n = pm_hit(ALG_BCRYPT);
      PM_D5:    if (c == CH_DOLLAR) n = pm_hit(ALG_SHA256);
      PM_D6:    if (c == CH_DOLLAR) n = pm_hit(ALG_SHA512);
      PM_D7:    if (c == CH_DOLLAR) n = pm_hit(ALG_SCRYPT);
      PM_DY:    if (c == CH_DOLLAR) n = pm_hit(ALG_YESCRYPT);
      PM_DG:    if (c == "y") n = PM_DGY;
      PM_DGY:   if (c == CH_DOLLAR) n = pm_hit(ALG_GOSTYES);
      PM_BRACE: if (c == "S") n = PM_BS;
      PM_BS:    if (c == "H") n = PM_BSH;
      PM_BSH:   if (c == "A") n = PM_BSHA;
      PM_BSHA:  if (c == CH_RBRACE) n = pm_hit(ALG_SHA1B64);
      default: begin
        // hold a completed match, otherwise stay dead
        if (s >= PM_HIT && s <= PM_HIT_HI) n = s;
      end
    endcase
    prefix_next = n;
  endfunction

  // Character of the crypt alphabet [A-Za-z0-9./]
  function automatic logic is_crypt_char(input logic [7:0] c);
    is_crypt_char = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                    (c >= "a" && c <= "z") || c == "." || c == "/";
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/password_hash_line_scanner_core.sv =====
// ----------------------------------------------------------------------------
// password_hash_line_scanner_core
// Streams a password file byte by byte and reports crypt hash findings.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle on the in_ stream (in_tlast marks
// the final byte of a file) and gives at most one finding per line, when the
// line ends at a newline or at the final byte. The only thing that holds the
// input back is a finding still waiting in the output register while
// out_tready is low. The user must write the layout register through cfg_ only
// while no byte is in flight; the block does not enforce it. After the final
// byte all counters restart at offset 0 for the next file; offsets saturate.
`default_nettype none

module password_hash_line_scanner_core #(
  parameter int unsigned OFFSET_BITS = phls_pkg::OFFSET_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data,     // [1:0] file_kind
  // byte stream in
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] byte_value
  input  wire logic        in_tlast,     // end_of_data
  // findings out
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,    // [3:0] algorithm, [4] weak_hash,
                                         // [36:5] byte_offset, [39:37] zero
  output logic             out_tuser     // finding_kind
);

  import phls_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  // Registers
  logic [1:0]             file_kind_r;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] line_start_r, line_start_nxt;
  logic [OFFSET_BITS-1:0] hash_start_r, hash_start_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [3:0]             hlen_r, hlen_nxt;
  pm_t                    prefix_r, prefix_nxt;
  logic                   charset_r, charset_nxt;
  logic [1:0]             first_cls_r, first_cls_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_kind_r;
  logic [3:0]             out_alg_r;
  logic                   out_weak_r;
  logic [OFFSET_BITS-1:0] out_off_r;

  // Per-byte working values
  logic                   in_fire;
  logic [7:0]             ch;
  logic                   is_nl;
  logic [OFFSET_BITS-1:0] pos_inc;
  phase_t                 phase_p;
  logic [3:0]             hlen_p;
  pm_t                    prefix_p;
  logic                   charset_p;
  logic [1:0]             first_cls_p;
  logic [OFFSET_BITS-1:0] hash_start_p;
  logic                   found;
  logic                   f_kind;
  logic [3:0]             f_alg;
  logic                   f_weak;
  logic [OFFSET_BITS-1:0] f_off;
  logic [4:0]             alg_diff;
  logic [OUT_OFFSET_BITS-1:0] out_off_sat;

  assign cfg_ready = 1'b1;
  assign in_tready = ~out_valid_r | out_tready;
  assign in_fire   = in_tvalid & in_tready;
  assign ch        = in_tdata;
  assign is_nl     = (ch == CH_NL);
  assign pos_inc   = (pos_r == OFF_MAX) ? pos_r : pos_r + 1'b1;
  assign alg_diff  = prefix_p - PM_HIT;

  // Hold the layout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_kind_r <= KIND_NONE;
    end else if (cfg_valid && cfg_ready) begin
      file_kind_r <= cfg_data;
    end
  end

  // Apply the byte to the line state
  always_comb begin
    phase_p      = phase_r;
    hlen_p       = hlen_r;
    prefix_p     = prefix_r;
    charset_p    = charset_r;
    first_cls_p  = first_cls_r;
    hash_start_p = hash_start_r;
    if (!is_nl) begin
      case (phase_r)
        PH_START: begin
          phase_p = (ch == CH_HASH || ch == CH_COLON) ? PH_SKIP : PH_USER;
        end
        PH_USER: begin
          if (ch == CH_COLON) begin
            phase_p      = PH_HASH;
            hash_start_p = pos_inc;
          end
        end
        PH_HASH: begin
          if (file_kind_r == KIND_SHADOW && ch == CH_COLON) begin
            phase_p = PH_AFTER;
          end else begin
            if (hlen_r == 4'd0) begin
              first_cls_p = (ch == CH_STAR || ch == CH_BANG) ? CLS_LOCK : CLS_OTHER;
            end
            if (hlen_r != HLEN_MAX) begin
              hlen_p = hlen_r + 4'd1;
            end
            charset_p = charset_r & is_crypt_char(ch);
            prefix_p  = prefix_next(prefix_r, ch);
          end
        end
        PH_AFTER: begin
          phase_p = PH_AFTER;
        end
        default: begin
          phase_p = PH_SKIP;
        end
      endcase
    end
  end

  // Classify the line when it ends
  always_comb begin
    found  = 1'b0;
    f_kind = FIND_HASH;
    f_alg  = ALG_MD5CRYPT;
    f_weak = 1'b0;
    f_off  = hash_start_p;
    if ((is_nl || in_tlast) &&
        (file_kind_r == KIND_SHADOW || file_kind_r == KIND_HTPASSWD) &&
        (phase_p == PH_HASH || phase_p == PH_AFTER)) begin
      if (hlen_p == 4'd0) begin
        if (file_kind_r == KIND_SHADOW) begin
          found  = 1'b1;
          f_kind = FIND_EMPTY_PW;
          f_off  = line_start_r;
        end
      end else if (file_kind_r == KIND_SHADOW && first_cls_p == CLS_LOCK) begin
        found = 1'b0;
      end else if (prefix_p >= PM_HIT && prefix_p <= PM_HIT_HI) begin
        found  = 1'b1;
        f_alg  = alg_diff[3:0];
        f_weak = (f_alg == ALG_MD5CRYPT || f_alg == ALG_APR1 || f_alg == ALG_SHA1B64);
      end else if (hlen_p == DES_LEN && charset_p) begin
        found  = 1'b1;
        f_alg  = ALG_DESCRYPT;
        f_weak = 1'b1;
      end
    end
  end

  // Pick the state after the byte: restart on a line end or file end
  always_comb begin
    pos_nxt        = pos_r;
    line_start_nxt = line_start_r;
    hash_start_nxt = hash_start_r;
    phase_nxt      = phase_r;
    hlen_nxt       = hlen_r;
    prefix_nxt     = prefix_r;
    charset_nxt    = charset_r;
    first_cls_nxt  = first_cls_r;
    if (in_fire) begin
      if (in_tlast || is_nl) begin
        pos_nxt        = in_tlast ? '0 : pos_inc;
        line_start_nxt = in_tlast ? '0 : pos_inc;
        hash_start_nxt = '0;
        phase_nxt      = PH_START;
        hlen_nxt       = 4'd0;
        prefix_nxt     = PM_START;
        charset_nxt    = 1'b1;
        first_cls_nxt  = CLS_NONE;
      end else begin
        pos_nxt        = pos_inc;
        hash_start_nxt = hash_start_p;
        phase_nxt      = phase_p;
        hlen_nxt       = hlen_p;
        prefix_nxt     = prefix_p;
        charset_nxt    = charset_p;
        first_cls_nxt  = first_cls_p;
      end
    end
  end

  // Hold the line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      line_start_r <= '0;
      hash_start_r <= '0;
      phase_r      <= PH_START;
      hlen_r       <= 4'd0;
      prefix_r     <= PM_START;
      charset_r    <= 1'b1;
      first_cls_r  <= CLS_NONE;
    end else begin
      pos_r        <= pos_nxt;
      line_start_r <= line_start_nxt;
      hash_start_r <= hash_start_nxt;
      phase_r      <= phase_nxt;
      hlen_r       <= hlen_nxt;
      prefix_r     <= prefix_nxt;
      charset_r    <= charset_nxt;
      first_cls_r  <= first_cls_nxt;
    end
  end

  // Output register: load a finding, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = found;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && found) begin
      out_kind_r <= f_kind;
      out_alg_r  <= f_alg;
      out_weak_r <= f_weak;
      out_off_r  <= f_off;
    end
  end

  // Saturate or zero-extend the offset to the 32-bit output field
  generate
    if (OFFSET_BITS > OUT_OFFSET_BITS) begin : g_off_wide
      assign out_off_sat = (|out_off_r[OFFSET_BITS-1:OUT_OFFSET_BITS]) ?
                           {OUT_OFFSET_BITS{1'b1}} : out_off_r[OUT_OFFSET_BITS-1:0];
    end else if (OFFSET_BITS == OUT_OFFSET_BITS) begin : g_off_same
      assign out_off_sat = out_off_r;
    end else begin : g_off_narrow
      assign out_off_sat = {{(OUT_OFFSET_BITS - OFFSET_BITS){1'b0}}, out_off_r};
    end
  endgenerate

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {3'b000, out_off_sat, out_weak_r, out_alg_r};

  // File end restarts the position count
  a_eod_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> pos_r == '0 && phase_r == PH_START)
    else $error("position not cleared after final byte");

  // Empty-password findings carry no algorithm and no weak flag
  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == FIND_EMPTY_PW |-> out_alg_r == ALG_MD5CRYPT && !out_weak_r)
    else $error("empty password finding with algorithm bits");

  // Matcher stays at its start until a hash character is seen
  a_prefix_idle: assert property (@(posedge clk) disable iff (!rst_n)
    hlen_r == 4'd0 |-> prefix_r == PM_START && first_cls_r == CLS_NONE && charset_r)
    else $error("prefix matcher moved without hash characters");

  // Scanning off: a byte never raises a finding
  a_kind_none: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && file_kind_r == KIND_NONE |=> !out_valid_r)
    else $error("finding reported with scanning off");

  // A waiting finding blocks the input
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while finding waits");

endmodule

`default_nettype wire
